/* rtl/core/sphere_projection_eccentricity_fix_macros.svh */
// Assertion macros for the sphere projection eccentricity fix block.
// Used by the top level only; no other dependencies.
`ifndef SPHERE_PROJECTION_ECCENTRICITY_FIX_MACROS_SVH
`define SPHERE_PROJECTION_ECCENTRICITY_FIX_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SPEF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spef: same-cycle check failed");

// Next-cycle implication.
`define SPEF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spef: next-cycle check failed");

`endif

/* rtl/core/spef_pkg.sv */
// Shared widths, reset values, register indexes and control types for the
// eccentricity fix pipeline. No dependencies.
package spef_pkg;

    localparam int FRAC_BITS = 16;

    localparam int POS_W  = 26;   // detector coordinates
    localparam int SDD_W  = 27;
    localparam int PP_W   = 16;
    localparam int AX_W   = 16;   // half axes
    localparam int OFF_W  = POS_W + 1;          // offset from principal point
    localparam int PROD_W = AX_W + PP_W;        // half axis times pitch
    localparam int SQ_W   = 2 * PROD_W;         // its square
    localparam int OSQ_W  = 2 * OFF_W;          // squared offset
    localparam int SSQ_W  = 2 * SDD_W;          // squared distance
    localparam int DEN0_W = OSQ_W + 1;          // sum of two squared offsets
    localparam int HALF_W = SQ_W / 2;
    localparam int PART_W = HALF_W + OFF_W;
    localparam int NUM_W  = PART_W + HALF_W + 2;
    localparam int DSH    = 18;                 // den scale: 2 * axis frac + 2
    localparam int DEN_W  = DEN0_W + DSH;
    localparam int QB     = POS_W;              // quotient bits before saturation
    localparam int REM_W  = DEN_W + QB;
    localparam int DLAT   = QB + 2;             // divider register stages
    localparam int FRONT  = 5;                  // stages ahead of the divider
    localparam int TOT    = FRONT + DLAT;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SDD_W;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 56;

    localparam logic [SDD_W-1:0] SDD_RST =
        SDD_W'((64'd1000 << FRAC_BITS) & ((64'd1 << SDD_W) - 64'd1));
    localparam logic [PP_W-1:0] PP_RST =
        PP_W'((((64'd1 << FRAC_BITS) + 64'd5) / 64'd10) & ((64'd1 << PP_W) - 64'd1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRINCIPAL_X = 3'd0,
        CFG_PRINCIPAL_Y = 3'd1,
        CFG_SDD         = 3'd2,
        CFG_PIXEL_PITCH = 3'd3,
        CFG_MODE        = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        MODE_AXIS_DIFF = 1'b0,
        MODE_DISTANCE  = 1'b1
    } t_mode;

    typedef struct packed {
        logic neg;    // negate the rounded magnitude
        logic zero;   // force result to zero
    } t_div_ctl;

endpackage

/* rtl/core/spef_div.sv */
// Pipelined restoring divider with round-to-nearest and saturation,
// one quotient bit per stage. Depends on spef_pkg.
module spef_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [spef_pkg::NUM_W-1:0] i_num,
    input  logic [spef_pkg::DEN_W-1:0] i_den,
    input  spef_pkg::t_div_ctl        i_ctl,
    output logic [spef_pkg::QB-1:0]    o_quot
);
    import spef_pkg::*;

    logic [REM_W-1:0] r_rem [0:QB];
    logic [QB-1:0]    r_q   [0:QB];
    logic [DEN_W-1:0] r_d   [0:QB];
    logic             r_ovf [0:QB];
    t_div_ctl         r_ctl [0:QB];
    logic [QB-1:0]    r_quot;

    // Stage 0: a quotient of 2^QB or more always saturates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REM_W'(i_num);
            r_q[0]   <= '0;
            r_d[0]   <= i_den;
            r_ovf[0] <= REM_W'(i_num) >= (REM_W'(i_den) << QB);
            r_ctl[0] <= i_ctl;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        localparam int BIT = QB - k;
        logic [REM_W:0] w_trial;
        assign w_trial = {1'b0, r_rem[k-1]} - {1'b0, REM_W'(r_d[k-1]) << BIT};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_trial[REM_W] ? r_rem[k-1] : w_trial[REM_W-1:0];
                r_q[k]   <= r_q[k-1] | (QB'(!w_trial[REM_W]) << BIT);
                r_d[k]   <= r_d[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    logic          w_round;
    logic [QB:0]   w_qr;
    logic [QB:0]   w_lim;
    logic [QB:0]   w_mag;
    logic [QB-1:0] n_quot;

    always_comb begin
        w_round = {r_rem[QB][DEN_W-1:0], 1'b0} >= {1'b0, r_d[QB]};
        w_qr    = {1'b0, r_q[QB]} + (QB+1)'(w_round);
        w_lim   = r_ctl[QB].neg ? ((QB+1)'(1) << (QB-1))
                                : (((QB+1)'(1) << (QB-1)) - (QB+1)'(1));
        w_mag   = (r_ovf[QB] || (w_qr > w_lim)) ? w_lim : w_qr;
        if (r_ctl[QB].zero) begin
            n_quot = '0;
        end else if (r_ctl[QB].neg) begin
            n_quot = QB'((~w_mag) + (QB+1)'(1));
        end else begin
            n_quot = w_mag[QB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

/* rtl/core/sphere_projection_eccentricity_fix.sv */
// Marker ellipse centre eccentricity correction, fully pipelined.
// Depends on spef_pkg, spef_div and the assertion macro header.
//
// Usage:
//   Input beats on s_axis carry one ellipse: tdata = sensor_x, sensor_y,
//   half_major, half_minor. Output beats on m_axis carry shift_x, shift_y in
//   tdata and on_axis in tuser. Each input beat yields exactly one output beat.
//   Configuration registers (principal point, source-detector distance, pixel
//   pitch, correction mode) go through i_cfg_wr_en / i_cfg_idx / i_cfg_wdata;
//   the user writes them only with no beat in flight; this is not enforced.
// Depth: 5 front stages for the offsets, squares and numerator partial
//   products, 28 register stages in the divider.
// Throughput: one beat per cycle while the output is not stalled. The divider
//   retires one quotient bit per stage, which sets the depth; each divider
//   step is one wide compare and subtract.
// Reset: synchronous, active low; clears all valid bits and loads register
//   defaults (principal 0, distance 1000 mm, pitch 0.1 mm, distance mode).
// Stall: when the output beat is held, the whole pipeline freezes and
//   s_axis tready drops; nothing is dropped or repeated.
`include "sphere_projection_eccentricity_fix_macros.svh"

module sphere_projection_eccentricity_fix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // sensor_x[25:0], sensor_y[51:26], half_major[67:52], half_minor[83:68]
    input  logic [spef_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // shift_x[25:0], shift_y[51:26]
    output logic [spef_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // on_axis[0]
    output logic                                o_m_axis_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic [spef_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spef_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import spef_pkg::*;

    // configuration
    logic [POS_W-1:0] r_px;
    logic [POS_W-1:0] r_py;
    logic [SDD_W-1:0] r_sdd;
    logic [PP_W-1:0]  r_pp;
    t_mode            r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= '0;
            r_py   <= '0;
            r_sdd  <= SDD_RST;
            r_pp   <= PP_RST;
            r_mode <= MODE_DISTANCE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_PRINCIPAL_X: r_px   <= i_cfg_wdata[POS_W-1:0];
                CFG_PRINCIPAL_Y: r_py   <= i_cfg_wdata[POS_W-1:0];
                CFG_SDD:         r_sdd  <= i_cfg_wdata[SDD_W-1:0];
                CFG_PIXEL_PITCH: r_pp   <= i_cfg_wdata[PP_W-1:0];
                CFG_MODE:        r_mode <= t_mode'(i_cfg_wdata[0]);
                default: ;
            endcase
        end
    end

    logic           w_en;
    logic [TOT-1:0] r_vld;

    assign w_en            = !r_vld[TOT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT-2:0], i_s_axis_tvalid};
        end
    end

    logic [POS_W-1:0] w_sx;
    logic [POS_W-1:0] w_sy;
    logic [AX_W-1:0]  w_hm;
    logic [AX_W-1:0]  w_hn;

    assign w_sx = i_s_axis_tdata[POS_W-1:0];
    assign w_sy = i_s_axis_tdata[2*POS_W-1:POS_W];
    assign w_hm = i_s_axis_tdata[2*POS_W+AX_W-1:2*POS_W];
    assign w_hn = i_s_axis_tdata[2*POS_W+2*AX_W-1:2*POS_W+AX_W];

    // stage 1: offsets and half axes in metric units
    logic [OFF_W-1:0]  r1_ex, r1_ey;
    logic [PROD_W-1:0] r1_p, r1_q;
    logic [SDD_W-1:0]  r1_sdd;
    t_mode             r1_mode;

    // stage 2: magnitudes and squares
    logic [OFF_W-1:0]  r2_ax, r2_ay;
    logic              r2_xneg, r2_yneg, r2_zero;
    logic [SQ_W-1:0]   r2_pp, r2_qq;
    logic [SSQ_W-1:0]  r2_ss;
    t_mode             r2_mode;

    // stage 3: axis term and squared offsets
    logic [OFF_W-1:0]  r3_ax, r3_ay;
    logic [OSQ_W-1:0]  r3_ax2, r3_ay2;
    logic [SQ_W-1:0]   r3_d;
    logic              r3_xneg, r3_yneg, r3_zero;
    logic [SSQ_W-1:0]  r3_ss;
    t_mode             r3_mode;

    // stage 4: denominator and numerator partial products
    logic [DEN0_W-1:0] r4_den;
    logic [PART_W-1:0] r4_xl, r4_xh, r4_yl, r4_yh;
    logic              r4_xneg, r4_yneg, r4_zero;

    // stage 5: full numerators
    logic [NUM_W-1:0]  r5_nx, r5_ny;
    logic [DEN_W-1:0]  r5_d;
    logic              r5_xneg, r5_yneg, r5_zero;

    logic [SQ_W-1:0]   w_pq;
    logic [SQ_W-1:0]   w_qp;

    assign w_pq = r2_pp - r2_qq;
    assign w_qp = r2_qq - r2_pp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ex   <= {w_sx[POS_W-1], w_sx} - {r_px[POS_W-1], r_px};
            r1_ey   <= {w_sy[POS_W-1], w_sy} - {r_py[POS_W-1], r_py};
            r1_p    <= PROD_W'(w_hm) * PROD_W'(r_pp);
            r1_q    <= PROD_W'(w_hn) * PROD_W'(r_pp);
            r1_sdd  <= (r_sdd == '0) ? SDD_W'(1) : r_sdd;
            r1_mode <= r_mode;

            r2_ax   <= r1_ex[OFF_W-1] ? (~r1_ex + OFF_W'(1)) : r1_ex;
            r2_ay   <= r1_ey[OFF_W-1] ? (~r1_ey + OFF_W'(1)) : r1_ey;
            r2_xneg <= r1_ex[OFF_W-1];
            r2_yneg <= r1_ey[OFF_W-1];
            r2_zero <= (r1_ex == '0) && (r1_ey == '0);
            r2_pp   <= SQ_W'(r1_p) * SQ_W'(r1_p);
            r2_qq   <= SQ_W'(r1_q) * SQ_W'(r1_q);
            r2_ss   <= SSQ_W'(r1_sdd) * SSQ_W'(r1_sdd);
            r2_mode <= r1_mode;

            // axis difference flips the sign when the minor axis is larger
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_ax2  <= OSQ_W'(r2_ax) * OSQ_W'(r2_ax);
            r3_ay2  <= OSQ_W'(r2_ay) * OSQ_W'(r2_ay);
            if (r2_mode == MODE_AXIS_DIFF) begin
                r3_d    <= (r2_qq > r2_pp) ? w_qp : w_pq;
                r3_xneg <= r2_xneg ^ (r2_qq > r2_pp);
                r3_yneg <= r2_yneg ^ (r2_qq > r2_pp);
            end else begin
                r3_d    <= r2_qq;
                r3_xneg <= r2_xneg;
                r3_yneg <= r2_yneg;
            end
            r3_zero <= r2_zero;
            r3_ss   <= r2_ss;
            r3_mode <= r2_mode;

            r4_den  <= (r3_mode == MODE_AXIS_DIFF)
                       ? (DEN0_W'(r3_ax2) + DEN0_W'(r3_ay2)) : DEN0_W'(r3_ss);
            r4_xl   <= PART_W'(r3_d[HALF_W-1:0]) * PART_W'(r3_ax);
            r4_xh   <= PART_W'(r3_d[SQ_W-1:HALF_W]) * PART_W'(r3_ax);
            r4_yl   <= PART_W'(r3_d[HALF_W-1:0]) * PART_W'(r3_ay);
            r4_yh   <= PART_W'(r3_d[SQ_W-1:HALF_W]) * PART_W'(r3_ay);
            r4_xneg <= r3_xneg;
            r4_yneg <= r3_yneg;
            r4_zero <= r3_zero;

            // full axes are twice the half axes: squares carry a factor of 4
            r5_nx   <= ((NUM_W'(r4_xh) << HALF_W) + NUM_W'(r4_xl)) << 2;
            r5_ny   <= ((NUM_W'(r4_yh) << HALF_W) + NUM_W'(r4_yl)) << 2;
            r5_d    <= DEN_W'(r4_den) << DSH;
            r5_xneg <= r4_xneg;
            r5_yneg <= r4_yneg;
            r5_zero <= r4_zero;
        end
    end

    t_div_ctl          w_ctl_x, w_ctl_y;
    logic [QB-1:0]     w_qx, w_qy;
    logic [DLAT-1:0]   r_onax;

    assign w_ctl_x = '{neg: r5_xneg, zero: r5_zero};
    assign w_ctl_y = '{neg: r5_yneg, zero: r5_zero};

    spef_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r5_nx),
        .i_den  (r5_d),
        .i_ctl  (w_ctl_x),
        .o_quot (w_qx)
    );

    spef_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r5_ny),
        .i_den  (r5_d),
        .i_ctl  (w_ctl_y),
        .o_quot (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_onax <= {r_onax[DLAT-2:0], r5_zero};
        end
    end

    assign o_m_axis_tvalid = r_vld[TOT-1];
    assign o_m_axis_tdata  = {(OUT_DATA_W-2*QB)'(0), w_qy, w_qx};
    assign o_m_axis_tuser  = r_onax[DLAT-1];

    `SPEF_ASSERT_IMP(a_onax_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == '0)
    `SPEF_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !w_en, r_vld == $past(r_vld))
    `SPEF_ASSERT_NXT(a_accept_enter, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_vld[0])

endmodule
